### sv/ple_pkg.sv
// Package for the positional list engine: sizes, request codes and sequencer states.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_SWAP    = 2'd2,
        OP_SEARCH  = 2'd3
    } ple_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_WRITE,
        ST_EXT_RD,
        ST_EXT_CAP,
        ST_EXT_WR,
        ST_SWP_RD1,
        ST_SWP_RD2,
        ST_SWP_WR1,
        ST_SWP_WR2,
        ST_SCAN_START,
        ST_SCAN,
        ST_DONE
    } ple_state_t;

endpackage

### sv/ple_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/positional_list_engine_unit.sv
// Top level of the positional list engine: request sequencer, list memory and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a small RAM.
// A request word (req_type, position, second_position, word) is taken when req_valid is
// high and req_stall is low. The request kinds are insert at a 1-based position, extract
// the entry at a position, swap two positions, and search for a value. Each request gives
// exactly one result word on the res channel: the outcome flag, the extracted entry, the
// search hit, and a summary of the list after the request (count, largest entry, position
// of the first largest entry, and whether the list is non-decreasing).
//
// One request is handled at a time; req_stall is high while the sequencer is busy. Work
// is set by the single RAM read port, one entry per cycle: an insert into n entries moves
// up to n of them, an extract moves up to n-1, a swap reads both entries and writes them
// back, and every request ends with a summary pass over the entries left, then loads the
// result register.
//
// The result register parts the two sides: a new request is taken while the previous
// result still waits under res_stall, but its own result waits in the final step until
// the register is free. Reset empties the list and clears the result valid flag.
module positional_list_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         req_type,
    input  logic [4:0]         position,
    input  logic [4:0]         second_position,
    input  logic signed [31:0] word,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               op_ok,
    output logic signed [31:0] extracted_word,
    output logic               found,
    output logic [4:0]         entry_count,
    output logic signed [31:0] max_word,
    output logic [4:0]         max_position,
    output logic               is_sorted
);

    import ple_pkg::*;

    // Sequencer state and captured request.
    ple_state_t               state_reg, state_next;
    ple_op_t                  op_reg, op_next;
    logic [ADDR_W-1:0]        p1_reg, p1_next;
    logic [ADDR_W-1:0]        p2_reg, p2_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    // Result being built.
    logic                     ok_reg, ok_next;
    logic signed [WORD_W-1:0] extr_reg, extr_next;
    logic                     found_reg, found_next;
    logic signed [WORD_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]         maxp_reg, maxp_next;
    logic                     sorted_reg, sorted_next;
    logic signed [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0]        tmp_reg, tmp_next;

    // Result register toward the receiver.
    logic                     res_valid_reg, res_valid_next;
    logic                     out_ok_reg, out_ok_next;
    logic signed [WORD_W-1:0] out_extr_reg, out_extr_next;
    logic                     out_found_reg, out_found_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;
    logic signed [WORD_W-1:0] out_max_reg, out_max_next;
    logic [CNT_W-1:0]         out_maxp_reg, out_maxp_next;
    logic                     out_sorted_reg, out_sorted_next;

    // List memory port.
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [WORD_W-1:0]        wr_data;
    logic [ADDR_W-1:0]        rd_addr;
    logic [WORD_W-1:0]        rd_data;
    logic signed [WORD_W-1:0] rd_word;

    // Range checks on the request.
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         sec_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         idx_ext;
    logic                     ins_ok;
    logic                     ext_ok;
    logic                     swp_ok;
    logic                     req_take;

    ple_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_word = $signed(rd_data);
    assign pos_ext = CMP_W'(position);
    assign sec_ext = CMP_W'(second_position);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_ext = CMP_W'(idx_reg);

    assign ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1)
                    && (cnt_ext < CMP_W'(CAPACITY));
    assign ext_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign swp_ok = ext_ok && (sec_ext != '0) && (sec_ext <= cnt_ext);

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        word_reg       <= word_next;
        idx_reg        <= idx_next;
        ok_reg         <= ok_next;
        extr_reg       <= extr_next;
        found_reg      <= found_next;
        max_reg        <= max_next;
        maxp_reg       <= maxp_next;
        sorted_reg     <= sorted_next;
        prev_reg       <= prev_next;
        tmp_reg        <= tmp_next;
        out_ok_reg     <= out_ok_next;
        out_extr_reg   <= out_extr_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_max_reg    <= out_max_next;
        out_maxp_reg   <= out_maxp_next;
        out_sorted_reg <= out_sorted_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        word_next       = word_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        ok_next         = ok_reg;
        extr_next       = extr_reg;
        found_next      = found_reg;
        max_next        = max_reg;
        maxp_next       = maxp_reg;
        sorted_next     = sorted_reg;
        prev_next       = prev_reg;
        tmp_next        = tmp_reg;
        out_ok_next     = out_ok_reg;
        out_extr_next   = out_extr_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_max_next    = out_max_reg;
        out_maxp_next   = out_maxp_reg;
        out_sorted_next = out_sorted_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        rd_addr         = idx_reg;

        // The receiver takes the waiting result.
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    op_next    = ple_op_t'(req_type);
                    p1_next    = ADDR_W'(pos_ext - 1'b1);
                    p2_next    = ADDR_W'(sec_ext - 1'b1);
                    word_next  = word;
                    extr_next  = '0;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    state_next = ST_SCAN_START;
                    unique case (ple_op_t'(req_type))
                        OP_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ok_next = 1'b1;
                                if (pos_ext == cnt_ext + 1'b1)
                                begin
                                    // Append at the end: nothing to move.
                                    state_next = ST_INS_WRITE;
                                end
                                else
                                begin
                                    idx_next   = ADDR_W'(cnt_ext - 1'b1);
                                    state_next = ST_INS_RD;
                                end
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (ext_ok)
                            begin
                                ok_next    = 1'b1;
                                state_next = ST_EXT_RD;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (swp_ok)
                            begin
                                ok_next    = 1'b1;
                                state_next = ST_SWP_RD1;
                            end
                        end
                        OP_SEARCH:
                        begin
                            ok_next = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                rd_addr    = idx_reg;
                state_next = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                // Move entry idx up by one while the next lower entry is read.
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(idx_ext + 1'b1);
                wr_data = rd_data;
                if (idx_reg == p1_reg)
                begin
                    state_next = ST_INS_WRITE;
                end
                else
                begin
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_INS_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = p1_reg;
                wr_data    = word_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_SCAN_START;
            end
            ST_EXT_RD:
            begin
                rd_addr    = p1_reg;
                idx_next   = p1_reg;
                state_next = ST_EXT_CAP;
            end
            ST_EXT_CAP:
            begin
                extr_next  = rd_word;
                count_next = count_reg - 1'b1;
                if (idx_ext + 1'b1 < cnt_ext)
                begin
                    rd_addr    = ADDR_W'(idx_ext + 1'b1);
                    state_next = ST_EXT_WR;
                end
                else
                begin
                    state_next = ST_SCAN_START;
                end
            end
            ST_EXT_WR:
            begin
                // The count is already one less here, so the bound uses the new count.
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = ADDR_W'(idx_ext + 1'b1);
                if (idx_ext + 1'b1 < cnt_ext)
                begin
                    rd_addr = ADDR_W'(idx_ext + 2'd2);
                end
                else
                begin
                    state_next = ST_SCAN_START;
                end
            end
            ST_SWP_RD1:
            begin
                rd_addr    = p1_reg;
                state_next = ST_SWP_RD2;
            end
            ST_SWP_RD2:
            begin
                rd_addr    = p2_reg;
                tmp_next   = rd_data;
                state_next = ST_SWP_WR1;
            end
            ST_SWP_WR1:
            begin
                wr_en      = 1'b1;
                wr_addr    = p1_reg;
                wr_data    = rd_data;
                state_next = ST_SWP_WR2;
            end
            ST_SWP_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = p2_reg;
                wr_data    = tmp_reg;
                state_next = ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                idx_next    = '0;
                max_next    = '0;
                maxp_next   = '0;
                sorted_next = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((op_reg == OP_SEARCH) && (rd_word == word_reg))
                begin
                    found_next = 1'b1;
                end
                if (idx_reg == '0)
                begin
                    max_next  = rd_word;
                    maxp_next = CNT_W'(1);
                end
                else
                begin
                    if (rd_word > max_reg)
                    begin
                        max_next  = rd_word;
                        maxp_next = CNT_W'(idx_ext + 1'b1);
                    end
                    if (rd_word < prev_reg)
                    begin
                        sorted_next = 1'b0;
                    end
                end
                prev_next = rd_word;
                if (idx_ext + 1'b1 < cnt_ext)
                begin
                    rd_addr  = ADDR_W'(idx_ext + 1'b1);
                    idx_next = ADDR_W'(idx_ext + 1'b1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    out_ok_next     = ok_reg;
                    out_extr_next   = extr_reg;
                    out_found_next  = found_reg;
                    out_count_next  = count_reg;
                    out_max_next    = max_reg;
                    out_maxp_next   = maxp_reg;
                    out_sorted_next = sorted_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign op_ok          = out_ok_reg;
    assign extracted_word = out_extr_reg;
    assign found          = out_found_reg;
    assign entry_count    = 5'(out_count_reg);
    assign max_word       = out_max_reg;
    assign max_position   = 5'(out_maxp_reg);
    assign is_sorted      = out_sorted_reg;

    // The list never holds more entries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // A new result appears only from the final step of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // Placing the new entry of an insert grows the list by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_WRITE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list by one");

    // A waiting result is not overwritten while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> (res_valid_reg && $stable(out_extr_reg)
                                          && $stable(out_count_reg)))
        else $error("stalled result changed");

endmodule

### sim/positional_list_engine_unit_test.sv
// Self-checking testbench for the positional list engine with a class-based list scoreboard.
`timescale 1ns / 100ps

module positional_list_engine_unit_test;

    import ple_pkg::*;

    localparam int RANDOM_ITEMS   = 530;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 64;

    // One result word as the block should present it.
    typedef struct {
        logic               ok;
        logic signed [31:0] extracted;
        logic               hit;
        logic [4:0]         count;
        logic signed [31:0] top_word;
        logic [4:0]         top_pos;
        logic               ordered;
    } list_result_t;

    // Mirrors the list contents and queues the result each accepted request should give.
    class list_scoreboard;
        logic signed [31:0] entries[$];
        list_result_t       pending_results[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        function int size();
            return entries.size();
        endfunction

        function logic signed [31:0] entry(int idx);
            return entries[idx];
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Applies one accepted request to the mirrored list and queues its result.
        task note_request(ple_op_t op, logic [4:0] p1, logic [4:0] p2,
                          logic signed [31:0] w);
            list_result_t       r;
            logic signed [31:0] held;
            int                 n;
            int                 i;
            n = entries.size();
            r = '{default: '0};
            r.ordered = 1'b1;
            case (op)
                OP_INSERT:
                    if (p1 >= 1 && p1 <= n + 1 && n < CAPACITY)
                    begin
                        entries.insert(p1 - 1, w);
                        r.ok = 1'b1;
                    end
                OP_EXTRACT:
                    if (p1 >= 1 && p1 <= n)
                    begin
                        r.extracted = entries[p1 - 1];
                        entries.delete(p1 - 1);
                        r.ok = 1'b1;
                    end
                OP_SWAP:
                    if (p1 >= 1 && p1 <= n && p2 >= 1 && p2 <= n)
                    begin
                        held = entries[p1 - 1];
                        entries[p1 - 1] = entries[p2 - 1];
                        entries[p2 - 1] = held;
                        r.ok = 1'b1;
                    end
                default:
                begin
                    r.ok = 1'b1;
                    foreach (entries[k])
                        if (entries[k] == w)
                            r.hit = 1'b1;
                end
            endcase
            // The summary always describes the list as it stands afterwards.
            r.count = 5'(entries.size());
            if (entries.size() > 0)
            begin
                r.top_word = entries[0];
                r.top_pos = 5'd1;
                for (i = 1; i < entries.size(); i++)
                begin
                    if (entries[i] > r.top_word)
                    begin
                        r.top_word = entries[i];
                        r.top_pos = 5'(i + 1);
                    end
                    if (entries[i] < entries[i - 1])
                        r.ordered = 1'b0;
                end
            end
            pending_results.push_back(r);
        endtask

        task check_result(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result word arrived with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("op_ok got %0b want %0b", got.ok, want.ok));
            if (got.extracted !== want.extracted)
                report($sformatf("extracted_word got %0d want %0d",
                                 got.extracted, want.extracted));
            if (got.hit !== want.hit)
                report($sformatf("found got %0b want %0b", got.hit, want.hit));
            if (got.count !== want.count)
                report($sformatf("entry_count got %0d want %0d", got.count, want.count));
            if (got.top_word !== want.top_word)
                report($sformatf("max_word got %0d want %0d", got.top_word, want.top_word));
            if (got.top_pos !== want.top_pos)
                report($sformatf("max_position got %0d want %0d",
                                 got.top_pos, want.top_pos));
            if (got.ordered !== want.ordered)
                report($sformatf("is_sorted got %0b want %0b", got.ordered, want.ordered));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         req_type;
    logic [4:0]         position;
    logic [4:0]         second_position;
    logic signed [31:0] word;
    logic               res_valid;
    logic               res_stall;
    logic               op_ok;
    logic signed [31:0] extracted_word;
    logic               found;
    logic [4:0]         entry_count;
    logic signed [31:0] max_word;
    logic [4:0]         max_position;
    logic               is_sorted;

    list_scoreboard sb;
    bit             quiet_run;
    int             idle_cycles;

    positional_list_engine_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .position        (position),
        .second_position (second_position),
        .word            (word),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .op_ok           (op_ok),
        .extracted_word  (extracted_word),
        .found           (found),
        .entry_count     (entry_count),
        .max_word        (max_word),
        .max_position    (max_position),
        .is_sorted       (is_sorted)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycles without any word moving on either channel; reset to zero on every handshake.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: samples right after the edge, so the values seen are the ones the
    // block presented at that edge, then picks the stall for the next cycle.
    initial
    begin
        list_result_t got;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                got.ok = op_ok;
                got.extracted = extracted_word;
                got.hit = found;
                got.count = entry_count;
                got.top_word = max_word;
                got.top_pos = max_position;
                got.ordered = is_sorted;
                sb.check_result(got);
            end
            res_stall <= !quiet_run && ($urandom_range(0, 99) < 29);
        end
    end

    // Presents one request word, holding it steady until the block takes it.
    task automatic send_request(ple_op_t op, logic [4:0] p1, logic [4:0] p2,
                                logic signed [31:0] w);
        while (!quiet_run && $urandom_range(0, 99) < 29)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= op;
        position <= p1;
        second_position <= p2;
        word <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(op, p1, p2, w);
    endtask

    // Holds the request side off until every outstanding result has been taken.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Small values give duplicates and search hits; the extremes stress signed compares.
    function automatic logic signed [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $signed($urandom_range(0, 4)) - 2;
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh7FFF_FFFE;
                default: return 32'sh8000_0001;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly a legal position; otherwise anything the 5-bit field can carry.
    function automatic logic [4:0] pick_position(int span);
        if (span > 0 && $urandom_range(0, 99) < 85)
            return 5'($urandom_range(1, span));
        return 5'($urandom_range(0, 31));
    endfunction

    // Growing phases fill the list up to the full rejection, shrinking phases empty it.
    task automatic send_random(bit grow);
        ple_op_t            op;
        int                 n;
        int                 r;
        logic signed [31:0] w;
        n = sb.size();
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 15))
            op = OP_INSERT;
        else if (r < 70)
            op = OP_EXTRACT;
        else if (r < 85)
            op = OP_SWAP;
        else
            op = OP_SEARCH;
        w = pick_word();
        if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1) == 1)
            w = sb.entry($urandom_range(0, n - 1));
        send_request(op, pick_position(op == OP_INSERT ? n + 1 : n), pick_position(n), w);
    endtask

    initial
    begin
        int phase_left;
        bit grow;
        sb = new();
        quiet_run = 1'b0;
        phase_left = 0;
        grow = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_type <= OP_INSERT;
        position <= '0;
        second_position <= '0;
        word <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: search misses, extract and swap are refused, bad inserts too.
        send_request(OP_SEARCH,  5'd0,  5'd0,  32'sd0);
        send_request(OP_EXTRACT, 5'd1,  5'd0,  32'sd0);
        send_request(OP_SWAP,    5'd1,  5'd1,  32'sd0);
        send_request(OP_INSERT,  5'd0,  5'd0,  32'sd5);
        send_request(OP_INSERT,  5'd2,  5'd0,  32'sd5);
        // Build the list from the extremes, inserting at front, end and middle.
        send_request(OP_INSERT,  5'd1,  5'd0,  32'sh7FFF_FFFF);
        send_request(OP_INSERT,  5'd1,  5'd0,  32'sh8000_0000);
        send_request(OP_INSERT,  5'd3,  5'd0,  -32'sd1);
        send_request(OP_INSERT,  5'd2,  5'd0,  32'sd0);
        // A second copy of the largest word; the first copy's position must be reported.
        send_request(OP_INSERT,  5'd3,  5'd0,  32'sh7FFF_FFFF);
        send_request(OP_SEARCH,  5'd0,  5'd0,  32'sh7FFF_FFFF);
        send_request(OP_SEARCH,  5'd0,  5'd0,  32'sd7);
        // Swaps: with itself, end to end, then a zero, a past-the-end and an all-ones position.
        send_request(OP_SWAP,    5'd2,  5'd2,  32'sd0);
        send_request(OP_SWAP,    5'd1,  5'd5,  32'sd0);
        send_request(OP_SWAP,    5'd0,  5'd2,  32'sd0);
        send_request(OP_SWAP,    5'd2,  5'd6,  32'sd0);
        send_request(OP_SWAP,    5'd31, 5'd31, 32'sd0);
        // Extracts: refused at zero and past the end, then last, first and middle entries.
        send_request(OP_EXTRACT, 5'd0,  5'd0,  32'sd0);
        send_request(OP_EXTRACT, 5'd6,  5'd0,  32'sd0);
        send_request(OP_EXTRACT, 5'd5,  5'd0,  32'sd0);
        send_request(OP_EXTRACT, 5'd1,  5'd0,  32'sd0);
        send_request(OP_EXTRACT, 5'd2,  5'd0,  32'sd0);
        wait_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (phase_left == 0)
            begin
                grow = !grow;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            // A stretch where neither side inserts any gap.
            quiet_run = (k >= 250 && k < 350);
            if (k % 100 == 99)
                wait_drained();
            send_random(grow);
        end

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
